@@ hw/rtl/s7u_pkg.sv @@
// Shared types and constants for the seven-bit packed text unpacker.
package s7u_pkg;

    localparam int unsigned RESULT_SLOTS = 3;

    localparam logic [3:0] MODE_PAIR  = 4'h0;
    localparam logic [3:0] MODE_PLAIN = 4'h1;
    localparam logic [2:0] PHASE_LAST = 3'd6;
    localparam logic [2:0] PHASE_WRAP = 3'd7;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BAD_HEADER   = 2'd1,
        STATUS_LEFTOVER     = 2'd2,
        STATUS_MISSING_HALF = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] buffer;
        logic [2:0]  phase;
        logic [6:0]  accum;
        logic        half_pending;
        logic        plain_mode;
        logic        skipping;
    } s7u_state_t;

    typedef struct packed {
        logic [15:0] code_unit;
        status_t     status;
        logic        end_of_string;
    } s7u_result_t;

    typedef struct packed {
        s7u_result_t [RESULT_SLOTS-1:0] res;
        logic [1:0]                     cnt;
    } s7u_bundle_t;

endpackage

@@ hw/rtl/s7u_decode.sv @@
// Decode logic: one byte plus the string state gives the next state and up to three results.
module s7u_decode (
    input  s7u_pkg::s7u_state_t  state,
    input  logic [7:0]           data_byte,
    input  logic                 is_first,
    input  logic                 is_last,
    output s7u_pkg::s7u_state_t  state_next,
    output s7u_pkg::s7u_bundle_t bundle
);
    import s7u_pkg::*;

    s7u_state_t  st;
    s7u_bundle_t bd;
    logic [3:0]  mode;
    logic [2:0]  ph;
    logic [15:0] buf_w;
    logic [6:0]  grp;

    assign mode = data_byte[7:4];

    always_comb
    begin
        st    = state;
        bd    = '0;
        ph    = state.phase;
        buf_w = state.buffer;
        grp   = '0;

        if (is_first)
        begin
            st.buffer       = '0;
            st.phase        = '0;
            st.accum        = '0;
            st.half_pending = 1'b0;
            st.skipping     = 1'b0;
            if (mode != MODE_PAIR && mode != MODE_PLAIN)
            begin
                st.plain_mode = 1'b0;
                st.skipping   = 1'b1;
                bd.res[0]     = '{code_unit: 16'h0000, status: STATUS_BAD_HEADER,
                                  end_of_string: 1'b1};
                bd.cnt        = 2'd1;
            end
            else
            begin
                st.plain_mode = (mode == MODE_PLAIN);
                if (is_last)
                begin
                    st.skipping = 1'b1;
                    bd.res[0]   = '{code_unit: 16'h0000, status: STATUS_OK,
                                    end_of_string: 1'b1};
                    bd.cnt      = 2'd1;
                end
            end
        end
        else if (!state.skipping)
        begin
            if (ph >= PHASE_WRAP)
            begin
                ph = '0;
            end
            buf_w = state.buffer | ({8'h00, data_byte} << ph);

            // A second group is taken when the phase is about to wrap.
            for (int k = 0; k < 2; k++)
            begin
                if (k == 0 || ph == PHASE_LAST)
                begin
                    grp   = buf_w[6:0];
                    buf_w = buf_w >> 7;
                    if (st.plain_mode)
                    begin
                        bd.res[bd.cnt] = '{code_unit: {9'h000, grp}, status: STATUS_OK,
                                           end_of_string: 1'b0};
                        bd.cnt         = bd.cnt + 2'd1;
                    end
                    else if (!st.half_pending)
                    begin
                        st.accum        = grp;
                        st.half_pending = 1'b1;
                    end
                    else
                    begin
                        bd.res[bd.cnt]  = '{code_unit: {1'b0, grp, 1'b0, st.accum},
                                            status: STATUS_OK, end_of_string: 1'b0};
                        bd.cnt          = bd.cnt + 2'd1;
                        st.half_pending = 1'b0;
                    end
                end
            end

            st.buffer = buf_w;
            st.phase  = (ph == PHASE_LAST) ? 3'd0 : ph + 3'd1;

            if (is_last)
            begin
                if (buf_w != 16'h0000)
                begin
                    bd.res[bd.cnt] = '{code_unit: 16'h0000, status: STATUS_LEFTOVER,
                                       end_of_string: 1'b1};
                end
                else if (!st.plain_mode && st.half_pending)
                begin
                    bd.res[bd.cnt] = '{code_unit: 16'h0000, status: STATUS_MISSING_HALF,
                                       end_of_string: 1'b1};
                end
                else
                begin
                    bd.res[bd.cnt] = '{code_unit: 16'h0000, status: STATUS_OK,
                                       end_of_string: 1'b1};
                end
                bd.cnt      = bd.cnt + 2'd1;
                st.skipping = 1'b1;
            end
        end
    end

    assign state_next = st;
    assign bundle     = bd;

endmodule

@@ hw/rtl/s7u_emit.sv @@
// Result register: holds a decoded bundle, one result out per cycle unless stalled.
module s7u_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_valid,
    output logic                 load_ready,
    input  s7u_pkg::s7u_bundle_t bundle,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [15:0]          code_unit,
    output logic [1:0]           status,
    output logic                 end_of_string
);
    import s7u_pkg::*;

    s7u_result_t [RESULT_SLOTS-1:0] res_reg;
    logic [1:0]                     cnt_reg;
    logic [1:0]                     idx_reg;
    logic                           last_slot;
    s7u_result_t                    cur;

    assign result_valid = (cnt_reg != 2'd0);
    assign last_slot    = (idx_reg == cnt_reg - 2'd1);
    // The register frees up in the same cycle its final result is taken.
    assign load_ready   = !result_valid || (result_ready && last_slot);

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur = res_reg[0];
            2'd1:    cur = res_reg[1];
            2'd2:    cur = res_reg[2];
            default: cur = res_reg[0];
        endcase
    end

    assign code_unit     = cur.code_unit;
    assign status        = cur.status;
    assign end_of_string = cur.end_of_string;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load_ready)
        begin
            cnt_reg <= load_valid ? bundle.cnt : 2'd0;
            idx_reg <= '0;
        end
        else if (result_ready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            res_reg <= bundle.res;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (idx_reg < cnt_reg))
        else $error("result index past bundle count");

    a_eos_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && end_of_string) |-> last_slot)
        else $error("closing result is not the final one of its bundle");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(idx_reg)))
        else $error("stalled result moved");

endmodule

@@ hw/rtl/seven_bit_unpack_to_utf16_unit.sv @@
// Top level of the seven-bit packed text unpacker.
// A request passes the input register, then the result register, before its first
// result is offered. Throughput: one request per cycle while each yields at most one
// result taken at once; else the single result port paces (up to three per byte).
// Reset clears the string state (pair mode, not skipping) and empties both registers.
module seven_bit_unpack_to_utf16_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_first,
    input  logic        is_last,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [15:0] code_unit,
    output logic [1:0]  status,
    output logic        end_of_string
);
    import s7u_pkg::*;

    logic        in_vld_reg;
    logic [7:0]  data_reg;
    logic        first_reg;
    logic        last_reg;
    s7u_state_t  state_reg;
    s7u_state_t  state_next;
    s7u_bundle_t bundle;
    logic        emit_ready;
    logic        advance;

    assign advance    = in_vld_reg && emit_ready;
    assign item_ready = !in_vld_reg || emit_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            state_reg  <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                in_vld_reg <= item_valid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            data_reg  <= data_byte;
            first_reg <= is_first;
            last_reg  <= is_last;
        end
    end

    s7u_decode u_decode (
        .state      (state_reg),
        .data_byte  (data_reg),
        .is_first   (first_reg),
        .is_last    (last_reg),
        .state_next (state_next),
        .bundle     (bundle)
    );

    s7u_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_valid    (in_vld_reg),
        .load_ready    (emit_ready),
        .bundle        (bundle),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .code_unit     (code_unit),
        .status        (status),
        .end_of_string (end_of_string)
    );

    a_phase_below_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != PHASE_WRAP)
        else $error("byte phase reached the wrap value");

    a_skip_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg.skipping && !first_reg) |-> (bundle.cnt == 2'd0))
        else $error("skipped byte produced results");

endmodule
